/* rtl/core/mesh_table_interpolator_defines.svh */
// assertion macros for the mesh table interpolator checker
// no dependencies; included by files that carry assertions
`ifndef MESH_TABLE_INTERPOLATOR_DEFINES_SVH
`define MESH_TABLE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MTI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mesh table interpolator check failed");

// next-cycle implication, disabled in reset
`define MTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mesh table interpolator check failed");

`endif

/* rtl/core/mti_pkg.sv */
// shared constants, codes and types of the mesh table interpolator
// no dependencies
package mti_pkg;

  localparam int MESH_POINTS = 64;
  localparam int COLUMNS     = 4;
  localparam int SLICES      = 4;
  localparam int AHEAD       = 3;
  localparam int ADDR_W      = $clog2(MESH_POINTS);
  localparam int LEN_W       = $clog2(MESH_POINTS + 1);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int SLICE_W     = $clog2(SLICES);
  localparam int SAMP_DEPTH  = SLICES * COLUMNS * MESH_POINTS;
  localparam int SAMP_AW     = SLICE_W + COL_W + ADDR_W;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int SUM_W       = 56;
  localparam int STEP_W      = 31;
  localparam int CFG_IDX_W   = 2;

  // action codes
  localparam logic [1:0] ACT_WR_COORD  = 2'd0;
  localparam logic [1:0] ACT_WR_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_INTERP    = 2'd2;
  localparam logic [1:0] ACT_AVERAGE   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MESH_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESH_STEP   = 2'd1;

  // one queued item with its class
  typedef struct packed {
    logic               wr_coord;
    logic               wr_sample;
    logic               average;
    logic [1:0]         action;
    logic [1:0]         slice_z;
    logic [1:0]         column_x;
    logic [5:0]         point_index;
    logic signed [31:0] write_value;
    logic signed [31:0] query_start;
    logic signed [31:0] query_stop;
  } item_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic [32:0] rem0;
    logic [32:0] den;
    logic [31:0] low;
  } div_cmd_t;

endpackage

/* rtl/core/mti_front.sv */
// front end: accepts input beats, classifies them, queues two items
// depends on mti_pkg
module mti_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [111:0]   s_tdata,
  input  logic [1:0]     s_tuser,
  output mti_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_pop
);

  mti_pkg::item_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  mti_pkg::item_t in_item;
  logic           push;

  // unpack and classify the incoming beat
  always_comb begin
    in_item.action      = s_tuser;
    in_item.slice_z     = s_tdata[1:0];
    in_item.column_x    = s_tdata[3:2];
    in_item.point_index = s_tdata[9:4];
    in_item.write_value = s_tdata[41:10];
    in_item.query_start = s_tdata[73:42];
    in_item.query_stop  = s_tdata[105:74];
    in_item.wr_coord    = (s_tuser == mti_pkg::ACT_WR_COORD);
    in_item.wr_sample   = (s_tuser == mti_pkg::ACT_WR_SAMPLE);
    in_item.average     = (s_tuser == mti_pkg::ACT_AVERAGE);
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (item_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(item_pop);
    end
  end

endmodule

/* rtl/core/mti_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle, 32-bit quotient
// depends on mti_pkg
module mti_divider (
  input  logic              clk,
  input  logic              rst,
  input  mti_pkg::div_cmd_t cmd,
  output logic              done,
  output logic [31:0]       quot
);

  logic [32:0]                   rem;
  logic [32:0]                   den;
  logic [31:0]                   low;
  logic                          busy;
  logic [mti_pkg::DIV_CNT_W-1:0] cnt;
  logic [33:0]                   trial;
  logic                          ge;

  assign trial = {rem, low[31]};
  assign ge    = (trial >= {1'b0, den});

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= cmd.rem0;
      den <= cmd.den;
      low <= cmd.low;
    end else if (busy) begin
      rem  <= ge ? 33'(trial - {1'b0, den}) : trial[32:0];
      quot <= {quot[30:0], ge};
      low  <= {low[30:0], 1'b0};
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == mti_pkg::DIV_CNT_W'(mti_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/mti_back.sv */
// back end: table memories, interval search, interpolation and averaging
// depends on mti_pkg; drives the divider and the output register
module mti_back (
  input  logic                        clk,
  input  logic                        rst,
  input  mti_pkg::item_t              item,
  input  logic                        item_valid,
  output logic                        item_pop,
  input  logic [6:0]                  mesh_length,
  input  logic [mti_pkg::STEP_W-1:0]  mesh_step,
  output mti_pkg::div_cmd_t           div_cmd,
  input  logic                        div_done,
  input  logic [31:0]                 div_quot,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic signed [31:0]          result_value,
  output logic                        out_of_mesh,
  output logic                        saturated
);

  localparam int AW = mti_pkg::ADDR_W;
  localparam int LW = mti_pkg::LEN_W;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN     = 4'd1;
  localparam logic [3:0] ST_SCAN_END = 4'd2;
  localparam logic [3:0] ST_PAIR     = 4'd3;
  localparam logic [3:0] ST_AHEAD    = 4'd4;
  localparam logic [3:0] ST_DECIDE   = 4'd5;
  localparam logic [3:0] ST_IDIV     = 4'd6;
  localparam logic [3:0] ST_IADD     = 4'd7;
  localparam logic [3:0] ST_AV_MUL   = 4'd8;
  localparam logic [3:0] ST_AV_ACC   = 4'd9;
  localparam logic [3:0] ST_ADIV_SET = 4'd10;
  localparam logic [3:0] ST_ADIV     = 4'd11;
  localparam logic [3:0] ST_DONE     = 4'd12;

  logic [3:0]         state;
  mti_pkg::item_t     cur;
  logic [LW-1:0]      len;
  logic [LW-1:0]      len_clamped;
  logic [LW-1:0]      scan_i;
  logic [LW-1:0]      scan_idx;
  logic [AW-1:0]      best;
  logic [AW-1:0]      k;
  logic signed [31:0] c0;
  logic signed [31:0] x0;
  logic signed [31:0] x1;
  logic signed [31:0] s0;
  logic signed [31:0] s1;
  logic signed [mti_pkg::SUM_W-1:0] sum;
  logic [64:0]        prod;
  logic               prod_neg;
  logic               brk;
  logic               neg;
  logic signed [31:0] res;
  logic               oom;
  logic               sat;

  // memories
  logic signed [31:0] coord_mem [mti_pkg::MESH_POINTS];
  logic signed [31:0] samp_mem  [mti_pkg::SAMP_DEPTH];
  logic [AW-1:0]      c_raddr;
  logic [AW-1:0]      s_idx;
  logic signed [31:0] c_rdata;
  logic signed [31:0] s_rdata;
  logic               c_we;
  logic               s_we;

  // combinational helpers
  logic               avg_go;
  logic               x_ok;
  logic signed [32:0] span;
  logic [32:0]        span_mag;
  logic [mti_pkg::SUM_W-1:0] sum_mag;
  logic               span_zero;
  logic               q_ovf;
  logic               neg_now;
  logic [31:0]        limit;
  logic signed [32:0] d;
  logic [32:0]        d_mag;
  logic [31:0]        s_mag;
  logic [46:0]        term;
  logic [31:0]        q_mag;
  logic               q_sat;

  assign item_pop = (state == ST_IDLE) && item_valid;
  assign c_we     = item_pop && item.wr_coord;
  assign s_we     = item_pop && item.wr_sample;
  assign scan_idx = scan_i - 1'b1;

  // clamp of the mesh length to the usable range
  always_comb begin
    if (mesh_length < LW'(2)) len_clamped = LW'(2);
    else if (mesh_length > LW'(mti_pkg::MESH_POINTS)) len_clamped = LW'(mti_pkg::MESH_POINTS);
    else len_clamped = mesh_length;
  end

  // read addresses per state
  always_comb begin
    c_raddr = best;
    s_idx   = best;
    case (state)
      ST_SCAN:   c_raddr = scan_i[AW-1:0];
      ST_PAIR:   c_raddr = best + 1'b1;
      ST_AHEAD: begin
        c_raddr = best + AW'(mti_pkg::AHEAD);
        s_idx   = best + 1'b1;
      end
      ST_AV_ACC: begin
        c_raddr = k + 1'b1;
        s_idx   = k + 1'b1;
      end
      default: begin
        c_raddr = best;
        s_idx   = best;
      end
    endcase
  end

  // coordinate table
  always_ff @(posedge clk) begin
    if (c_we) coord_mem[item.point_index] <= item.write_value;
    c_rdata <= coord_mem[c_raddr];
  end

  // sample table, one row per slice and column
  always_ff @(posedge clk) begin
    if (s_we) samp_mem[{item.slice_z, item.column_x, item.point_index}] <= item.write_value;
    s_rdata <= samp_mem[{cur.slice_z, cur.column_x, s_idx}];
  end

  // decisions and operands
  always_comb begin
    avg_go    = cur.average && (({1'b0, best} + LW'(mti_pkg::AHEAD)) < len) &&
                (c_rdata < cur.query_stop);
    x_ok      = (x1 > x0);
    span      = 33'(cur.query_stop) - 33'(cur.query_start);
    span_mag  = span[32] ? 33'(-span) : span;
    sum_mag   = sum[mti_pkg::SUM_W-1] ? mti_pkg::SUM_W'(-sum) : mti_pkg::SUM_W'(sum);
    span_zero = (span == '0);
    q_ovf     = (sum_mag >= {7'd0, span_mag, 16'd0});
    neg_now   = sum[mti_pkg::SUM_W-1] != span[32];
    limit     = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    d         = 33'(s1) - 33'(s0);
    d_mag     = d[32] ? 33'(-d) : d;
    s_mag     = s_rdata[31] ? 32'(-33'(s_rdata)) : 32'(s_rdata);
    term      = prod[62:16];
    q_sat     = (div_quot > limit);
    q_mag     = q_sat ? limit : div_quot;
  end

  // divider requests
  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.rem0  = 33'(cur.query_start) - 33'(x0);
    div_cmd.den   = 33'(x1) - 33'(x0);
    div_cmd.low   = '0;
    if (state == ST_DECIDE) begin
      div_cmd.start = !avg_go && x_ok;
    end else if (state == ST_ADIV_SET) begin
      div_cmd.start = !span_zero && !q_ovf;
      div_cmd.rem0  = sum_mag[48:16];
      div_cmd.den   = span_mag;
      div_cmd.low   = {sum_mag[15:0], 16'd0};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_pop) begin
          cur  <= item;
          len  <= len_clamped;
          best <= '0;
          res  <= '0;
          oom  <= 1'b0;
          sat  <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (scan_i != '0) begin
          if (scan_idx == '0) c0 <= c_rdata;
          if (c_rdata <= cur.query_start) begin
            best <= scan_idx[AW-1:0];
            x0   <= c_rdata;
          end
        end
      end
      ST_SCAN_END: begin
        if (cur.query_start < c0 || cur.query_start >= c_rdata) oom <= 1'b1;
      end
      ST_AHEAD: begin
        x1 <= c_rdata;
        s0 <= s_rdata;
      end
      ST_DECIDE: begin
        s1  <= s_rdata;
        k   <= best;
        sum <= '0;
        if (!avg_go && !x_ok) sat <= 1'b1;
      end
      ST_IDIV: begin
        if (div_done) prod <= d_mag * div_quot;
      end
      ST_IADD: begin
        res <= d[32] ? 32'(34'(s0) - 34'(prod[64:32])) : 32'(34'(s0) + 34'(prod[64:32]));
      end
      ST_AV_MUL: begin
        prod     <= s_mag * mesh_step;
        prod_neg <= s_rdata[31];
        brk      <= (c_rdata >= cur.query_stop);
      end
      ST_AV_ACC: begin
        sum <= prod_neg ? sum - mti_pkg::SUM_W'(term) : sum + mti_pkg::SUM_W'(term);
        k   <= k + 1'b1;
      end
      ST_ADIV_SET: begin
        neg <= neg_now;
        if (span_zero) begin
          sat <= 1'b1;
          if (sum_mag == '0) res <= '0;
          else res <= sum[mti_pkg::SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (q_ovf) begin
          sat <= 1'b1;
          res <= neg_now ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
      end
      ST_ADIV: begin
        if (div_done) begin
          if (q_sat) sat <= 1'b1;
          res <= neg ? 32'(-33'(q_mag)) : q_mag;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_i   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result beat valid: set on a new result, cleared when taken
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          scan_i <= '0;
          if (item_pop) state <= (item.wr_coord || item.wr_sample) ? ST_DONE : ST_SCAN;
        end
        ST_SCAN: begin
          scan_i <= scan_i + 1'b1;
          if (scan_i == len - 1'b1) state <= ST_SCAN_END;
        end
        ST_SCAN_END: begin
          if (cur.query_start < c0 || cur.query_start >= c_rdata) state <= ST_DONE;
          else state <= ST_PAIR;
        end
        ST_PAIR:   state <= ST_AHEAD;
        ST_AHEAD:  state <= ST_DECIDE;
        ST_DECIDE: begin
          if (avg_go) state <= ST_AV_MUL;
          else if (x_ok) state <= ST_IDIV;
          else state <= ST_DONE;
        end
        ST_IDIV:   if (div_done) state <= ST_IADD;
        ST_IADD:   state <= ST_DONE;
        ST_AV_MUL: state <= ST_AV_ACC;
        ST_AV_ACC: begin
          if (brk || {1'b0, k} == len - 1'b1) state <= ST_ADIV_SET;
          else state <= ST_AV_MUL;
        end
        ST_ADIV_SET: begin
          if (span_zero || q_ovf) state <= ST_DONE;
          else state <= ST_ADIV;
        end
        ST_ADIV:   if (div_done) state <= ST_DONE;
        ST_DONE: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      result_value <= res;
      out_of_mesh  <= oom;
      saturated    <= sat;
    end
  end

endmodule

/* rtl/core/mesh_table_interpolator.sv */
// Mesh table interpolator: a two-entry input queue feeds a sequential engine
// that writes the tables or answers a query; a result register holds one
// result beat. A query scans all L mesh points through the single
// coordinate memory port; an interpolation then uses the 32-step divider;
// an average multiplies and accumulates each summed point, then sets up
// the divide, divides and forms the result.
// Behind a waiting result the engine holds one finished item and the queue
// two more.
// depends on mti_pkg, mti_front, mti_back, mti_divider
module mesh_table_interpolator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slice_z, column_x, point_index, write_value, query_start, query_stop
  input  logic [111:0]                    s_tdata,
  // action
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // result_value
  output logic [31:0]                     m_tdata,
  // out_of_mesh, saturated
  output logic [1:0]                      m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  mti_pkg::item_t    item;
  logic              item_valid;
  logic              item_pop;
  mti_pkg::div_cmd_t div_cmd;
  logic              div_done;
  logic [31:0]       div_quot;
  logic [6:0]        mesh_length;
  logic [mti_pkg::STEP_W-1:0] mesh_step;
  logic signed [31:0] result_value;
  logic              out_of_mesh;
  logic              saturated;

  assign cfg_ready = 1'b1;
  assign m_tdata   = result_value;
  assign m_tuser   = {saturated, out_of_mesh};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_length <= 7'd64;
      mesh_step   <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mti_pkg::CFG_MESH_LENGTH: mesh_length <= cfg_data[6:0];
        mti_pkg::CFG_MESH_STEP:   mesh_step   <= cfg_data[mti_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  mti_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .done (div_done),
    .quot (div_quot)
  );

  mti_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_pop     (item_pop),
    .mesh_length  (mesh_length),
    .mesh_step    (mesh_step),
    .div_cmd      (div_cmd),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .result_value (result_value),
    .out_of_mesh  (out_of_mesh),
    .saturated    (saturated)
  );

endmodule

/* rtl/core/mti_checker.sv */
// port-level checks of the mesh table interpolator, bound to the top level
// depends on mesh_table_interpolator_defines.svh
`include "mesh_table_interpolator_defines.svh"

module mti_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a point outside the mesh gives zero
  `MTI_ASSERT_NOW(a_oom_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == 32'd0)

  // outside the mesh nothing is divided, so no saturation
  `MTI_ASSERT_NOW(a_oom_no_sat, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))

  // a stalled result beat holds
  `MTI_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind mesh_table_interpolator mti_checker u_mti_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
